[design/lcc_pkg.sv]
// Package with the shared types and codes of the line crossing counter.
package lcc_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int COORD_W     = 12;
    localparam int CENT_W      = 16;
    localparam int ID_W        = 8;
    localparam int OUT_COUNT_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_START_X = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_START_Y = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_END_X   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_END_Y   = 4'd3;

    localparam logic [1:0] CROSS_NONE   = 2'd0;
    localparam logic [1:0] CROSS_A_TO_B = 2'd1;
    localparam logic [1:0] CROSS_B_TO_A = 2'd2;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_A    = 2'd1,
        SIDE_B    = 2'd2
    } side_t;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [ID_W-1:0]   track_id;
        logic              track_inactive;
        logic [CENT_W-1:0] centroid_x;
        logic [CENT_W-1:0] centroid_y;
    } track_report_t;

    typedef struct packed {
        logic [1:0]             crossing;
        logic [OUT_COUNT_W-1:0] count_a_to_b;
        logic [OUT_COUNT_W-1:0] count_b_to_a;
    } crossing_result_t;

    typedef struct packed {
        logic  inactive;
        side_t side;
    } track_info_t;

endpackage

[design/lcc_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module lcc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/lcc_line_cfg.sv]
// Counting line registers and the side classification of a centroid.
module lcc_line_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [lcc_pkg::CENT_W-1:0]        centroid_x,
    input  logic [lcc_pkg::CENT_W-1:0]        centroid_y,
    output lcc_pkg::side_t                    side
);

    logic [lcc_pkg::COORD_W-1:0] start_x_reg;
    logic [lcc_pkg::COORD_W-1:0] start_y_reg;
    logic [lcc_pkg::COORD_W-1:0] end_x_reg;
    logic [lcc_pkg::COORD_W-1:0] end_y_reg;
    logic [lcc_pkg::COORD_W-1:0] adx;
    logic [lcc_pkg::COORD_W-1:0] ady;
    logic [lcc_pkg::CENT_W-1:0]  x0;
    logic [lcc_pkg::CENT_W-1:0]  y0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcc_pkg::REG_LINE_START_X: start_x_reg <= cfg_data;
                lcc_pkg::REG_LINE_START_Y: start_y_reg <= cfg_data;
                lcc_pkg::REG_LINE_END_X:   end_x_reg   <= cfg_data;
                lcc_pkg::REG_LINE_END_Y:   end_y_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        adx = (start_x_reg > end_x_reg) ? start_x_reg - end_x_reg : end_x_reg - start_x_reg;
        ady = (start_y_reg > end_y_reg) ? start_y_reg - end_y_reg : end_y_reg - start_y_reg;
        x0  = {start_x_reg, 4'b0000};
        y0  = {start_y_reg, 4'b0000};
        side = lcc_pkg::SIDE_NONE;
        if (adx < ady)
        begin
            if (centroid_x < x0)
            begin
                side = lcc_pkg::SIDE_A;
            end
            else if (centroid_x > x0)
            begin
                side = lcc_pkg::SIDE_B;
            end
        end
        else if (adx > ady)
        begin
            if (centroid_y > y0)
            begin
                side = lcc_pkg::SIDE_A;
            end
            else if (centroid_y < y0)
            begin
                side = lcc_pkg::SIDE_B;
            end
        end
    end

endmodule

[design/lcc_update.sv]
// Read-modify-write stage of the side table with forwarding, counters and result register.
module lcc_update #(
    parameter int ADDR_W      = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [ADDR_W-1:0]          acc_slot,
    input  lcc_pkg::track_info_t       acc_info,
    input  logic [1:0]                 rd_data,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output logic [1:0]                 wr_data,
    output logic                       done,
    output lcc_pkg::crossing_result_t  result
);

    logic                      s1_valid_reg;
    logic [ADDR_W-1:0]         s1_slot_reg;
    lcc_pkg::track_info_t      s1_info_reg;
    logic                      fwd_hit_reg;
    logic [1:0]                fwd_data_reg;
    logic [COUNT_WIDTH-1:0]    a_to_b_reg;
    logic [COUNT_WIDTH-1:0]    a_to_b_next;
    logic [COUNT_WIDTH-1:0]    b_to_a_reg;
    logic [COUNT_WIDTH-1:0]    b_to_a_next;
    logic                      done_reg;
    lcc_pkg::crossing_result_t result_reg;
    logic [1:0]                old_side;
    logic [1:0]                new_side;
    logic [1:0]                cross_code;

    always_comb
    begin
        old_side    = fwd_hit_reg ? fwd_data_reg : rd_data;
        new_side    = old_side;
        cross_code  = lcc_pkg::CROSS_NONE;
        a_to_b_next = a_to_b_reg;
        b_to_a_next = b_to_a_reg;
        if (s1_info_reg.inactive)
        begin
            new_side = lcc_pkg::SIDE_NONE;
        end
        else if (old_side != lcc_pkg::SIDE_NONE)
        begin
            if (old_side != s1_info_reg.side)
            begin
                new_side = lcc_pkg::SIDE_NONE;
                if (old_side == lcc_pkg::SIDE_A && s1_info_reg.side == lcc_pkg::SIDE_B)
                begin
                    cross_code  = lcc_pkg::CROSS_A_TO_B;
                    a_to_b_next = a_to_b_reg + 1'b1;
                end
                else if (old_side == lcc_pkg::SIDE_B && s1_info_reg.side == lcc_pkg::SIDE_A)
                begin
                    cross_code  = lcc_pkg::CROSS_B_TO_A;
                    b_to_a_next = b_to_a_reg + 1'b1;
                end
            end
        end
        else
        begin
            new_side = s1_info_reg.side;
        end
    end

    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_slot_reg;
    assign wr_data = new_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            a_to_b_reg   <= '0;
            b_to_a_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_hit_reg  <= accept && s1_valid_reg && (s1_slot_reg == acc_slot);
            done_reg     <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                a_to_b_reg <= a_to_b_next;
                b_to_a_reg <= b_to_a_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg  <= acc_slot;
            s1_info_reg  <= acc_info;
            fwd_data_reg <= new_side;
        end
        if (s1_valid_reg)
        begin
            result_reg.crossing     <= cross_code;
            result_reg.count_a_to_b <= lcc_pkg::OUT_COUNT_W'(a_to_b_next);
            result_reg.count_b_to_a <= lcc_pkg::OUT_COUNT_W'(b_to_a_next);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[design/line_crossing_counter.sv]
// Top level of the line crossing counter.
//
// Track reports enter on start/report and are taken at a rising edge where start is high
// and busy is low. Each report gives exactly one result word on result, marked by done
// for exactly one cycle; the receiver cannot stall, so a result is never held.
// A taken report is registered in the s1 stage and the side table read register, and its
// result and done are then registered in the result and done registers.
// Throughput: one report per cycle while busy is low; the side table read is registered,
// and a write from the report just ahead to the same slot is forwarded into the next one.
// Reset clears the line registers and both counters, then a clearing pass writes every
// side table entry, one per cycle, from 0 to MAX_TRACKS-1; busy is high during that pass.
// The counting line registers are written through cfg_valid/cfg_ready, cfg_index and
// cfg_data; cfg_ready is always high, and writes belong in times with no report in flight.
// The side table is one RAM with a registered read port.
module line_crossing_counter #(
    parameter int MAX_TRACKS  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lcc_pkg::track_report_t           report,
    output logic                             done,
    output lcc_pkg::crossing_result_t        result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(MAX_TRACKS);
    localparam int RECIP  = (65536 + MAX_TRACKS - 1) / MAX_TRACKS;

    lcc_pkg::ctrl_state_t state_reg;
    lcc_pkg::ctrl_state_t state_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    clr_addr_next;
    logic                 clr_we;
    logic                 clr_last;
    logic                 accept;
    logic [24:0]          id_prod;
    logic [8:0]           id_quot;
    logic [23:0]          id_rem;
    logic [ADDR_W-1:0]    slot;
    lcc_pkg::side_t       cur_side;
    lcc_pkg::track_info_t acc_info;
    logic                 upd_we;
    logic [ADDR_W-1:0]    upd_addr;
    logic [1:0]           upd_data;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [1:0]           ram_wdata;
    logic [1:0]           ram_rdata;

    // The id is reduced modulo the table depth by a reciprocal multiply.
    always_comb
    begin
        id_prod = 25'(report.track_id) * 25'(RECIP);
        id_quot = id_prod[24:16];
        id_rem  = 24'(report.track_id) - 24'(24'(id_quot) * 24'(MAX_TRACKS));
        slot    = id_rem[ADDR_W-1:0];
    end

    assign clr_last = (clr_addr_reg == ADDR_W'(MAX_TRACKS - 1));

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            lcc_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = lcc_pkg::ST_RUN;
                end
            end
            lcc_pkg::ST_RUN:
            begin
                state_next = lcc_pkg::ST_RUN;
            end
            default:
            begin
                state_next = lcc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            lcc_pkg::ST_CLEAR:
            begin
                busy   = 1'b1;
                clr_we = 1'b1;
            end
            lcc_pkg::ST_RUN:
            begin
                busy   = 1'b0;
                clr_we = 1'b0;
            end
            default:
            begin
                busy   = 1'b1;
                clr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lcc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    lcc_line_cfg u_line_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .centroid_x (report.centroid_x),
        .centroid_y (report.centroid_y),
        .side       (cur_side)
    );

    assign acc_info.inactive = report.track_inactive;
    assign acc_info.side     = cur_side;

    assign ram_we    = clr_we || upd_we;
    assign ram_waddr = clr_we ? clr_addr_reg : upd_addr;
    assign ram_wdata = clr_we ? lcc_pkg::SIDE_NONE : upd_data;

    lcc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_TRACKS)
    ) u_side_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    lcc_update #(
        .ADDR_W      (ADDR_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .acc_slot (slot),
        .acc_info (acc_info),
        .rd_data  (ram_rdata),
        .wr_en    (upd_we),
        .wr_addr  (upd_addr),
        .wr_data  (upd_data),
        .done     (done),
        .result   (result)
    );

endmodule
